### sv/rac_pkg.sv
`default_nettype none

package rac_pkg;

    localparam int VALUE_BITS_DEF = 31;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 5;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 5'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

    typedef logic [DIGIT_W-1:0] t_digit;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input t_digit d);
        logic [CHAR_W-1:0] r;
        if (d <= DIGIT_NINE) begin
            r = CHAR_ZERO + CHAR_W'(d);
        end else begin
            r = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return r;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
        logic [RADIX_W-1:0] r;
        if (v < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            r = RADIX_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/radix_ascii_converter_top.sv
`default_nettype none

// radix_ascii_converter_top
//
// converts a non-negative integer to ASCII digit characters in the radix held
// in the configuration register (2..32, reset 10, writes outside are clamped)
//
// request: i_value is taken at a clock edge with start high and busy low
// results: one character per cycle on o_digit_char, marked by o_digit_valid,
//   most significant first; o_last_digit flags the final character; a value
//   of zero gives the single character '0'
// configuration: i_cfg_data is written at an edge with i_cfg_we high; the user
//   must write it only while busy is low, the block itself does not enforce this
//
// each digit costs one full bit-serial division by the radix in the shared
//   divider; digits are stacked and then read back
// reset clears the controller and sets the radix to 10; stacked digits are
//   not cleared; the receiver cannot stall, characters leave at one per cycle

module radix_ascii_converter_top
    import rac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_cfg_we,
    input  wire logic [RADIX_W-1:0]    i_cfg_data,
    output      logic                  o_digit_valid,
    output      logic [CHAR_W-1:0]     o_digit_char,
    output      logic                  o_last_digit
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [RADIX_W-1:0]  r_radix, n_radix;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic                r_valid, n_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    t_digit              r_stack [VALUE_BITS];

    logic                  div_load;
    logic [VALUE_BITS-1:0] div_in;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    t_digit                div_digit;
    logic                  quo_zero;

    rac_div_serial #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (div_load),
        .i_dividend  (div_in),
        .i_radix     (r_radix),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_digit)
    );

    assign quo_zero = (div_quo == '0);

    always_comb begin
        n_radix = r_radix;
        if (i_cfg_we) begin
            n_radix = clamp_radix(i_cfg_data);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_valid  = 1'b0;
        div_load = 1'b0;
        div_in   = i_value;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    div_load = 1'b1;
                    n_cnt    = '0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_cnt = r_cnt + 1'b1;
                    if (quo_zero) begin
                        n_ptr   = r_cnt[IDX_W-1:0];
                        n_state = S_EMIT;
                    end else begin
                        div_load = 1'b1;
                        div_in   = div_quo;
                    end
                end
            end
            S_EMIT: begin
                n_valid = 1'b1;
                if (r_ptr == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= RADIX_RESET;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_radix <= n_radix;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_valid <= n_valid;
        end
    end

    // digit stack, least significant pushed first
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_done) begin
            r_stack[r_cnt[IDX_W-1:0]] <= div_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_char <= digit_to_ascii(r_stack[r_ptr]);
            r_last <= (r_ptr == '0);
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_digit_valid = r_valid;
    assign o_digit_char  = r_char;
    assign o_last_digit  = r_last;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |-> $past(r_state) == S_EMIT)
        else $error("character strobe without emit phase");

    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_valid && o_last_digit) |-> (r_state == S_IDLE))
        else $error("last character while request still active");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(VALUE_BITS))
        else $error("digit count beyond value width");

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX))
        else $error("radix register outside 2..32");

endmodule

`default_nettype wire

### sv/rac_div_serial.sv
`default_nettype none

module rac_div_serial
    import rac_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [RADIX_W-1:0]    i_radix,
    output      logic                  o_done,
    output      logic [VALUE_BITS-1:0] o_quotient,
    output      t_digit                o_remainder
);

    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [BIT_W-1:0]      r_bit;
    logic [VALUE_BITS-1:0] r_quo;
    t_digit                r_rem;

    logic [RADIX_W-1:0]    trial;
    logic                  q_bit;
    t_digit                n_rem;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        trial = {r_rem, r_quo[VALUE_BITS-1]};
        q_bit = (trial >= i_radix);
        if (q_bit) begin
            n_rem = DIGIT_W'(trial - i_radix);
        end else begin
            n_rem = DIGIT_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= r_busy && (r_bit == BIT_LAST);
            if (i_load) begin
                r_busy <= 1'b1;
                r_bit  <= '0;
            end else if (r_busy) begin
                r_bit <= r_bit + 1'b1;
                if (r_bit == BIT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire
